// ===== rtl/keyed_slot_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// keyed slot table assertion macros
// concurrent checks clocked by i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef KEYED_SLOT_TABLE_UNIT_ASSERT_SVH
`define KEYED_SLOT_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define KST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("keyed slot table check failed");

// consequent must hold in the cycle after the antecedent
`define KST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keyed slot table check failed");

`else

`define KST_ASSERT(lbl, prop)
`define KST_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// shared widths, codes and structs of the keyed slot table
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int DEF_SLOTS  = 32;
    localparam int MODE_W     = 2;
    localparam int KEY_W      = 32;
    localparam int SEQ_W      = 32;
    localparam int ID_W       = 6;
    localparam int SLOT_OUT_W = 5;
    localparam int CNT_OUT_W  = 6;
    localparam int STATUS_W   = 2;

    localparam logic [CNT_OUT_W-1:0] LIST_CAP = CNT_OUT_W'(32);

    typedef enum logic [MODE_W-1:0] {
        MODE_GET    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_LIST   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EXISTS   = 2'd1,
        ST_NOSPACE  = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_OUT_W-1:0]   slot_out;
        logic [SEQ_W-1:0]        seq;
        logic [KEY_W-1:0]        key_out;
        logic [CNT_OUT_W-1:0]    count;
        logic                    last;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [ID_W-1:0]    addr;
        logic [KEY_W-1:0]   key;
        logic [SEQ_W-1:0]   seq;
    } t_mem_wr;

endpackage

// ===== rtl/kst_in_if.sv =====
// ----------------------------------------------------------------------------
// kst_in_if
// request channel: valid/ready handshake with the request fields
// ----------------------------------------------------------------------------
interface kst_in_if import kst_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [KEY_W-1:0]       key;
    logic                   create;
    logic                   exclusive;
    logic [ID_W-1:0]        slot_id;
    logic [CNT_OUT_W-1:0]   max_count;

    modport source (
        output valid, mode, key, create, exclusive, slot_id, max_count,
        input  ready
    );

    modport sink (
        input  valid, mode, key, create, exclusive, slot_id, max_count,
        output ready
    );

endinterface

// ===== rtl/kst_out_if.sv =====
// ----------------------------------------------------------------------------
// kst_out_if
// result channel: valid/ready handshake with the result fields
// ----------------------------------------------------------------------------
interface kst_out_if import kst_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [SLOT_OUT_W-1:0]  slot_out;
    logic [SEQ_W-1:0]       seq;
    logic [KEY_W-1:0]       key_out;
    logic [CNT_OUT_W-1:0]   count;
    logic                   last;

    modport source (
        output valid, status, slot_out, seq, key_out, count, last,
        input  ready
    );

    modport sink (
        input  valid, status, slot_out, seq, key_out, count, last,
        output ready
    );

endinterface

// ===== rtl/kst_mem.sv =====
// ----------------------------------------------------------------------------
// kst_mem
// key and sequence store, one write port, one registered read port
// ----------------------------------------------------------------------------
module kst_mem import kst_pkg::*; #(
    parameter  int SLOTS = DEF_SLOTS,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic                i_clk,
    input  t_mem_wr             i_wr,
    input  logic [IDX_W-1:0]    i_rd_addr,
    output logic [KEY_W-1:0]    o_rd_key,
    output logic [SEQ_W-1:0]    o_rd_seq
);

    logic [KEY_W-1:0] r_key_mem [SLOTS];
    logic [SEQ_W-1:0] r_seq_mem [SLOTS];
    logic [KEY_W-1:0] r_rd_key;
    logic [SEQ_W-1:0] r_rd_seq;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_key_mem[i_wr.addr[IDX_W-1:0]] <= i_wr.key;
            r_seq_mem[i_wr.addr[IDX_W-1:0]] <= i_wr.seq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key <= r_key_mem[i_rd_addr];
        r_rd_seq <= r_seq_mem[i_rd_addr];
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_seq = r_rd_seq;

endmodule

// ===== rtl/kst_out_stage.sv =====
// ----------------------------------------------------------------------------
// kst_out_stage
// result register between the sequencer and the result channel
// ----------------------------------------------------------------------------
module kst_out_stage import kst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_res,
    output logic        o_free,
    kst_out_if.source   o_out
);

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_free         = !r_valid || o_out.ready;
    assign o_out.valid    = r_valid;
    assign o_out.status   = r_res.status;
    assign o_out.slot_out = r_res.slot_out;
    assign o_out.seq      = r_res.seq;
    assign o_out.key_out  = r_res.key_out;
    assign o_out.count    = r_res.count;
    assign o_out.last     = r_res.last;

endmodule

// ===== rtl/keyed_slot_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_table_unit
// query and remove: key/seq memory read in S_RD, result built in S_EVAL, loaded from S_OUT
// get: S_RD and S_EVAL per slot walked below the high-water mark, S_OUT on a hit or miss
// list: S_RD and S_EVAL per slot walked, S_OUT per result taken; stalls hold the walk
// one item at a time; input ready only while the sequencer is idle
// reset (sync, active low) clears valid bits, mark and counters; key/seq memory is not cleared
// ----------------------------------------------------------------------------
`include "keyed_slot_table_unit_assert.svh"

module keyed_slot_table_unit import kst_pkg::*; #(
    parameter  int SLOTS = DEF_SLOTS,
    localparam int IDX_W = $clog2(SLOTS),
    localparam int CNT_W = $clog2(SLOTS + 1),
    localparam int CW    = (CNT_W > ID_W) ? CNT_W : ID_W
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kst_in_if.sink      i_in,
    kst_out_if.source   o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_CREATE,
        ACT_REMOVE
    } t_act;

    t_state                 r_state,    n_state;
    t_mode                  r_mode,     n_mode;
    logic [KEY_W-1:0]       r_key,      n_key;
    logic                   r_create,   n_create;
    logic                   r_excl,     n_excl;
    logic [ID_W-1:0]        r_sid,      n_sid;
    logic [CNT_OUT_W-1:0]   r_lim,      n_lim;
    logic [CNT_OUT_W-1:0]   r_cnt,      n_cnt;
    logic [CNT_W-1:0]       r_idx,      n_idx;
    logic [CNT_W-1:0]       r_cand,     n_cand;
    logic                   r_cand_set, n_cand_set;
    logic                   r_live,     n_live;
    logic [CNT_W-1:0]       r_hw,       n_hw;
    logic [CNT_W-1:0]       r_used,     n_used;
    logic [SEQ_W-1:0]       r_next_seq, n_next_seq;
    logic [SLOTS-1:0]       r_valid,    n_valid;
    t_result                r_res,      n_res;
    t_act                   r_act,      n_act;

    t_mem_wr                mem_wr;
    logic [KEY_W-1:0]       rd_key;
    logic [SEQ_W-1:0]       rd_seq;
    logic                   rd_valid;
    logic                   more;
    logic                   out_free;
    logic                   out_load;
    logic [CNT_OUT_W-1:0]   cnt_inc;

    kst_mem #(.SLOTS(SLOTS)) u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_key  (rd_key),
        .o_rd_seq  (rd_seq)
    );

    kst_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (r_res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign rd_valid   = r_valid[r_idx[IDX_W-1:0]];
    assign cnt_inc    = r_cnt + CNT_OUT_W'(1);

    // another live slot above the current one, for the last flag of a list run
    always_comb begin
        more = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (r_valid[j] && (CNT_W'(j) > r_idx) && (CNT_W'(j) < r_hw)) begin
                more = 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_key      = r_key;
        n_create   = r_create;
        n_excl     = r_excl;
        n_sid      = r_sid;
        n_lim      = r_lim;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_cand     = r_cand;
        n_cand_set = r_cand_set;
        n_live     = r_live;
        n_hw       = r_hw;
        n_used     = r_used;
        n_next_seq = r_next_seq;
        n_valid    = r_valid;
        n_res      = r_res;
        n_act      = r_act;
        mem_wr     = '0;
        out_load   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode     = t_mode'(i_in.mode);
                    n_key      = i_in.key;
                    n_create   = i_in.create || (i_in.key == '0);
                    n_excl     = i_in.exclusive;
                    n_sid      = i_in.slot_id;
                    n_lim      = (i_in.max_count > LIST_CAP) ? LIST_CAP : i_in.max_count;
                    n_cnt      = '0;
                    n_cand     = r_hw;
                    n_cand_set = 1'b0;
                    n_act      = ACT_NONE;
                    n_live     = (CW'(i_in.slot_id) < CW'(r_hw))
                                 && r_valid[i_in.slot_id[IDX_W-1:0]];
                    case (t_mode'(i_in.mode))
                        MODE_GET: begin
                            // private key skips the walk and creates at the mark
                            n_idx = (i_in.key == '0) ? r_hw : '0;
                        end
                        MODE_REMOVE, MODE_QUERY: begin
                            n_idx = CNT_W'(i_in.slot_id);
                        end
                        default: begin
                            n_idx = '0;
                        end
                    endcase
                    n_state = S_RD;
                end
            end

            S_RD: begin
                case (r_mode)
                    MODE_GET: begin
                        if (r_idx >= r_hw) begin
                            n_res       = '0;
                            n_res.last  = 1'b1;
                            n_state     = S_OUT;
                            if (!r_create) begin
                                n_res.status = ST_NOTFOUND;
                            end else if (r_cand >= CNT_W'(SLOTS)) begin
                                n_res.status = ST_NOSPACE;
                            end else begin
                                n_res.status   = ST_OK;
                                n_res.slot_out = SLOT_OUT_W'(r_cand);
                                n_res.seq      = r_next_seq;
                                n_res.key_out  = r_key;
                                n_act          = ACT_CREATE;
                            end
                        end else begin
                            n_state = S_EVAL;
                        end
                    end
                    MODE_LIST: begin
                        // empty end result only taken with nothing listed yet
                        if ((r_idx >= r_hw) || (r_cnt >= r_lim)) begin
                            n_res        = '0;
                            n_res.status = ST_OK;
                            n_res.last   = 1'b1;
                            n_state      = S_OUT;
                        end else begin
                            n_state = S_EVAL;
                        end
                    end
                    default: begin
                        n_state = S_EVAL;
                    end
                endcase
            end

            S_EVAL: begin
                case (r_mode)
                    MODE_GET: begin
                        if (rd_valid && (rd_key == r_key)) begin
                            n_res.status   = (r_create && r_excl) ? ST_EXISTS : ST_OK;
                            n_res.slot_out = SLOT_OUT_W'(r_idx);
                            n_res.seq      = rd_seq;
                            n_res.key_out  = rd_key;
                            n_res.count    = '0;
                            n_res.last     = 1'b1;
                            n_state        = S_OUT;
                        end else begin
                            if (!rd_valid && !r_cand_set) begin
                                n_cand     = r_idx;
                                n_cand_set = 1'b1;
                            end
                            n_idx   = r_idx + CNT_W'(1);
                            n_state = S_RD;
                        end
                    end
                    MODE_LIST: begin
                        if (rd_valid) begin
                            n_res.status   = ST_OK;
                            n_res.slot_out = SLOT_OUT_W'(r_idx);
                            n_res.seq      = rd_seq;
                            n_res.key_out  = rd_key;
                            n_res.count    = cnt_inc;
                            n_res.last     = !more || (cnt_inc >= r_lim);
                            n_cnt          = cnt_inc;
                            n_state        = S_OUT;
                        end else begin
                            n_idx   = r_idx + CNT_W'(1);
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_res.slot_out = SLOT_OUT_W'(r_sid);
                        n_res.count    = '0;
                        n_res.last     = 1'b1;
                        if (r_live) begin
                            n_res.status  = ST_OK;
                            n_res.seq     = rd_seq;
                            n_res.key_out = rd_key;
                            n_act         = (r_mode == MODE_REMOVE) ? ACT_REMOVE : ACT_NONE;
                        end else begin
                            n_res.status  = ST_NOTFOUND;
                            n_res.seq     = '0;
                            n_res.key_out = '0;
                        end
                        n_state = S_OUT;
                    end
                endcase
            end

            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    case (r_act)
                        ACT_CREATE: begin
                            mem_wr.we   = 1'b1;
                            mem_wr.addr = ID_W'(r_cand);
                            mem_wr.key  = r_key;
                            mem_wr.seq  = r_next_seq;
                            n_valid[r_cand[IDX_W-1:0]] = 1'b1;
                            n_next_seq = r_next_seq + SEQ_W'(1);
                            n_used     = r_used + CNT_W'(1);
                            if (r_cand == r_hw) begin
                                n_hw = r_hw + CNT_W'(1);
                            end
                        end
                        ACT_REMOVE: begin
                            n_valid[r_idx[IDX_W-1:0]] = 1'b0;
                            n_used = r_used - CNT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                    n_act = ACT_NONE;
                    if (r_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_act      <= ACT_NONE;
            r_hw       <= '0;
            r_used     <= '0;
            r_next_seq <= '0;
            r_valid    <= '0;
        end else begin
            r_state    <= n_state;
            r_act      <= n_act;
            r_hw       <= n_hw;
            r_used     <= n_used;
            r_next_seq <= n_next_seq;
            r_valid    <= n_valid;
        end
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_create   <= n_create;
        r_excl     <= n_excl;
        r_sid      <= n_sid;
        r_lim      <= n_lim;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_cand     <= n_cand;
        r_cand_set <= n_cand_set;
        r_live     <= n_live;
        r_res      <= n_res;
    end

    `KST_ASSERT(a_used_within_mark, r_used <= r_hw)
    `KST_ASSERT(a_mark_within_slots, r_hw <= CNT_W'(SLOTS))
    `KST_ASSERT_NEXT(a_seq_step, out_load && (r_act == ACT_CREATE), r_next_seq == $past(r_next_seq) + SEQ_W'(1))
    `KST_ASSERT(a_list_within_limit, ((r_state == S_OUT) && (r_mode == MODE_LIST)) |-> (r_res.count <= r_lim))

endmodule
